### sv/lsa_pkg.sv
// ----------------------------------------------------------------------------
// lsa_pkg: shared types and constants for the LRU slot allocator
// Transfer structs, action codes, rank format and the cell command/status.
// ----------------------------------------------------------------------------
`default_nettype none

package lsa_pkg;

  // Slot row geometry.
  localparam int SLOT_COUNT = 16;
  localparam int TOP_RANK   = 15;

  // Field widths of the transfer structs.
  localparam int IDX_W   = 4;
  localparam int MASK_W  = 16;
  localparam int COUNT_W = 5;
  localparam int ACT_W   = 2;

  // Signed rank: -1 .. TOP_RANK.
  localparam int RANK_W = $clog2(TOP_RANK + 1) + 1;

  // Action codes.
  localparam logic [ACT_W-1:0] ACT_ALLOC   = 2'd0;
  localparam logic [ACT_W-1:0] ACT_TOUCH   = 2'd1;
  localparam logic [ACT_W-1:0] ACT_DEALLOC = 2'd2;

  typedef logic signed [RANK_W-1:0] lsa_rank_t;

  typedef struct packed {
    logic [ACT_W-1:0] action;
    logic [IDX_W-1:0] slot_index;
  } lsa_req_t;

  typedef struct packed {
    logic [IDX_W-1:0]   granted_slot;
    logic               evicted;
    logic [MASK_W-1:0]  used_mask;
    logic [COUNT_W-1:0] used_count;
    logic               queried_free;
  } lsa_rsp_t;

  // Broadcast command to every cell in the row.
  typedef struct packed {
    logic age_all;   // decrement every rank
    logic age_live;  // decrement every rank that is not negative
    logic set_top;   // selected cell takes TOP_RANK
    logic set_free;  // selected cell takes -1
  } lsa_cmd_t;

  // Per-cell status toward the sequencer.
  typedef struct packed {
    logic hit;   // first free candidate in the row
    logic used;  // rank above zero
    logic neg;   // rank negative
    logic top;   // rank equals TOP_RANK
  } lsa_cell_st_t;

endpackage

`default_nettype wire

### sv/lru_slot_allocator_16_core.sv
// ----------------------------------------------------------------------------
// lru_slot_allocator_16_core: least-recently-used slot allocator, 16 slots
// Row of rank cells driven by a small sequencer, with a registered result.
// ----------------------------------------------------------------------------
// One request is handled at a time. The slot row is a chain of 16 cells, each
// holding a signed rank (-1 .. 15); a sequencer broadcasts one command per
// cycle to the whole row, and that command sequence sets the latency.
// Allocate scans (scanning again after aging every rank when no slot is
// free) and then touches; touch and deallocate run a touch or a drop step;
// the unused action code goes straight to the report. The load waits further
// while the output register still holds a stalled result. in_stall_o is low
// only while the sequencer is idle. Results sit in an output register, so the
// next request is taken while an earlier result still waits for its transfer.
// A slot counts as used when its rank is above zero; allocate treats rank
// zero as free, while queried_free reports only a negative rank.
`default_nettype none

module lru_slot_allocator_16_core (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_stall_o,
  input  wire lsa_pkg::lsa_req_t in_data_i,
  output logic                   out_valid_o,
  input  wire logic              out_stall_i,
  output lsa_pkg::lsa_rsp_t      out_data_o
);
  import lsa_pkg::*;

  // Sequencer states.
  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_SCAN   = 3'd1;
  localparam logic [2:0] ST_TOUCH  = 3'd2;
  localparam logic [2:0] ST_DROP   = 3'd3;
  localparam logic [2:0] ST_REPORT = 3'd4;

  localparam int GROUPS = SLOT_COUNT / 4;

  logic [2:0]       state_q, state_d;
  logic [ACT_W-1:0] act_q;
  logic [IDX_W-1:0] idx_q;
  logic [IDX_W-1:0] gnt_q;
  logic             evict_q;
  logic             out_valid_q;
  lsa_rsp_t         out_data_q, out_data_d;

  lsa_cmd_t                    cmd;
  lsa_cell_st_t                cell_st [SLOT_COUNT];
  logic [SLOT_COUNT:0]         free_chain;
  logic [SLOT_COUNT-1:0]       sel_vec, hit_vec, used_vec, neg_vec, top_vec;
  logic [IDX_W-1:0]            tgt;
  logic [IDX_W-1:0]            gnt_enc;
  logic                        any_free, top_hit, in_xfer, load_out;

  // Count used slots in groups of four, then add the group counts.
  function automatic logic [COUNT_W-1:0] count_used(input logic [SLOT_COUNT-1:0] v);
    logic [COUNT_W-1:0] sum;
    logic [2:0]         grp;
    sum = '0;
    for (int g = 0; g < GROUPS; g++) begin
      grp = 3'(v[4*g]) + 3'(v[4*g+1]) + 3'(v[4*g+2]) + 3'(v[4*g+3]);
      sum = sum + COUNT_W'(grp);
    end
    return sum;
  endfunction

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_xfer    = in_valid_i && !in_stall_o;

  // ---- Cell row: free search ripples from slot 0 upward -------------------
  assign free_chain[0] = 1'b0;
  assign any_free      = free_chain[SLOT_COUNT];

  for (genvar i = 0; i < SLOT_COUNT; i++) begin : g_cell
    lsa_cell u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .cmd_i    (cmd),
      .sel_i    (sel_vec[i]),
      .free_i   (free_chain[i]),
      .free_o   (free_chain[i+1]),
      .status_o (cell_st[i])
    );
    assign hit_vec[i]  = cell_st[i].hit;
    assign used_vec[i] = cell_st[i].used;
    assign neg_vec[i]  = cell_st[i].neg;
    assign top_vec[i]  = cell_st[i].top;
    assign sel_vec[i]  = (tgt == IDX_W'(i));
  end

  // Encode the one-hot first-free flag; no hit encodes to slot 0.
  always_comb begin
    gnt_enc = '0;
    for (int i = 0; i < SLOT_COUNT; i++) begin
      gnt_enc = gnt_enc | (hit_vec[i] ? IDX_W'(i) : '0);
    end
  end

  // Allocate touches the granted slot; touch and deallocate use the request.
  assign tgt     = (act_q == ACT_ALLOC) ? gnt_q : idx_q;
  assign top_hit = |(sel_vec & top_vec);

  // ---- Sequencer ----------------------------------------------------------
  always_comb begin
    state_d  = state_q;
    cmd      = '0;
    load_out = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          unique case (in_data_i.action)
            ACT_ALLOC:   state_d = ST_SCAN;
            ACT_TOUCH:   state_d = ST_TOUCH;
            ACT_DEALLOC: state_d = ST_DROP;
            default:     state_d = ST_REPORT;
          endcase
        end
      end
      ST_SCAN: begin
        // No free slot on the first pass: age every rank and scan again.
        // After aging, take whatever the encoder gives.
        if (any_free || evict_q) begin
          state_d = ST_TOUCH;
        end else begin
          cmd.age_all = 1'b1;
        end
      end
      ST_TOUCH: begin
        // A slot already at the top rank leaves the row untouched.
        if (!top_hit) begin
          cmd.age_live = 1'b1;
          cmd.set_top  = 1'b1;
        end
        state_d = ST_REPORT;
      end
      ST_DROP: begin
        cmd.set_free = 1'b1;
        state_d      = ST_REPORT;
      end
      ST_REPORT: begin
        // Hold until the output register is empty or drains this cycle.
        if (!out_valid_q || !out_stall_i) begin
          load_out = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      act_q   <= ACT_ALLOC;
      idx_q   <= '0;
      gnt_q   <= '0;
      evict_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (in_xfer) begin
        act_q   <= in_data_i.action;
        idx_q   <= in_data_i.slot_index;
        gnt_q   <= '0;
        evict_q <= 1'b0;
      end else if (state_q == ST_SCAN) begin
        if (any_free || evict_q) begin
          gnt_q <= gnt_enc;
        end else begin
          evict_q <= 1'b1;
        end
      end
    end
  end

  // ---- Result register ----------------------------------------------------
  always_comb begin
    out_data_d.granted_slot = (act_q == ACT_ALLOC) ? gnt_q : '0;
    out_data_d.evicted      = evict_q;
    out_data_d.used_mask    = MASK_W'(used_vec);
    out_data_d.used_count   = count_used(used_vec);
    out_data_d.queried_free = neg_vec[idx_q];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load_out) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      out_data_q <= out_data_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  // ---- Assertions ---------------------------------------------------------
  // The free chain flags at most one first-free cell.
  a_single_hit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(hit_vec))
    else $error("more than one first-free cell");

  // After a touch step the selected slot holds the top rank.
  a_touch_top: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_TOUCH) |=> ((top_vec & $past(sel_vec)) != '0))
    else $error("touched slot not at top rank");

  // An eviction is only ever reported for an allocate.
  a_evict_alloc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (load_out && evict_q) |-> (act_q == ACT_ALLOC))
    else $error("eviction reported for a non-allocate request");

  // A result load never overwrites a result that is still stalled.
  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_out |-> (!out_valid_q || !out_stall_i))
    else $error("result register overrun");

endmodule

`default_nettype wire

### sv/lsa_cell.sv
// ----------------------------------------------------------------------------
// lsa_cell: one slot of the allocator row
// Holds the signed rank of a slot and joins the lowest-free search chain.
// ----------------------------------------------------------------------------
`default_nettype none

module lsa_cell (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire lsa_pkg::lsa_cmd_t     cmd_i,
  input  wire logic                  sel_i,
  input  wire logic                  free_i,
  output logic                       free_o,
  output lsa_pkg::lsa_cell_st_t      status_o
);
  import lsa_pkg::*;

  lsa_rank_t rank_q, rank_d;
  logic      cand;

  // Allocate treats rank zero as free.
  assign cand   = rank_q[RANK_W-1] || (rank_q == '0);
  assign free_o = free_i || cand;

  assign status_o.hit  = cand && !free_i;
  assign status_o.neg  = rank_q[RANK_W-1];
  assign status_o.used = !rank_q[RANK_W-1] && (rank_q != '0);
  assign status_o.top  = (rank_q == RANK_W'(TOP_RANK));

  always_comb begin
    rank_d = rank_q;
    priority if (sel_i && cmd_i.set_top) begin
      rank_d = RANK_W'(TOP_RANK);
    end else if (sel_i && cmd_i.set_free) begin
      rank_d = '1;
    end else if (cmd_i.age_all || (cmd_i.age_live && !rank_q[RANK_W-1])) begin
      rank_d = rank_q - RANK_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rank_q <= '1;
    end else begin
      rank_q <= rank_d;
    end
  end

endmodule

`default_nettype wire

### bench/tb_lru_slot_allocator_16_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_lru_slot_allocator_16_core: self-checking bench for the LRU slot allocator
// Replays a rank table of its own next to the block, applies every accepted
// request to it, and checks each response transfer field by field in order.
// ----------------------------------------------------------------------------

module tb_lru_slot_allocator_16_core;
  import lsa_pkg::*;

  // The package names three action codes; the fourth one is the unused code.
  localparam logic [ACT_W-1:0] ACT_UNUSED = 2'd3;

  localparam int CLK_PERIOD   = 20;
  localparam int RESET_CYCLES = 5;
  localparam int IDLE_PCT     = 19;      // chance per cycle that a side idles
  localparam int QUIET_FROM   = 300;     // no idling on either side in this
  localparam int QUIET_TO     = 460;     // window of transfer counts
  localparam int HOLD_AT      = 120;     // response count that starts the hold
  localparam int HOLD_CYCLES  = 80;      // length of the long receiver hold
  localparam int RANDOM_REQS  = 850;
  localparam int DRAIN_CYCLES = 8;       // extra clocks after the last response
  localparam int REPORT_MAX   = 10;
  localparam int TIMEOUT_NS   = 4_000_000;

  logic      clk_i     = 1'b0;
  logic      rst_ni    = 1'b0;
  logic      in_valid  = 1'b0;
  logic      in_stall;
  lsa_req_t  in_data   = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  lsa_rsp_t  out_data;

  // Requests waiting to be offered, and responses the rank table says are due.
  lsa_req_t  req_backlog_q[$];
  lsa_rsp_t  rsp_due_q[$];

  // Rank table of the bench, advanced at every accepted request.
  lsa_rank_t slot_rank_q[SLOT_COUNT];

  int        req_sent  = 0;
  int        rsp_taken = 0;
  int        mismatch_cnt = 0;
  int        hold_left = 0;
  logic      hold_done = 1'b0;

  wire sender_quiet   = (req_sent  >= QUIET_FROM) && (req_sent  < QUIET_TO);
  wire receiver_quiet = (rsp_taken >= QUIET_FROM) && (rsp_taken < QUIET_TO);

  lru_slot_allocator_16_core i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data)
  );

  initial begin
    forever #(CLK_PERIOD / 2) clk_i = ~clk_i;
  end

  // --------------------------------------------------------------------------
  // Rank table
  // --------------------------------------------------------------------------

  // Lowest slot that allocate may take (rank zero counts as free), -1 if none.
  function automatic int lowest_free_slot();
    for (int i = 0; i < SLOT_COUNT; i++) begin
      if (slot_rank_q[i] <= 0) return i;
    end
    return -1;
  endfunction

  // Make a slot the most recent one. A slot already on top is left alone;
  // otherwise age every live rank first, so a rank of zero drops to -1.
  function automatic void promote_slot(int slot);
    if (slot_rank_q[slot] == TOP_RANK) return;
    for (int i = 0; i < SLOT_COUNT; i++) begin
      if (slot_rank_q[i] >= 0) slot_rank_q[i] = slot_rank_q[i] - lsa_rank_t'(1);
    end
    slot_rank_q[slot] = lsa_rank_t'(TOP_RANK);
  endfunction

  // Apply one request to the rank table and return the response it must give.
  function automatic lsa_rsp_t apply_action(lsa_req_t req);
    lsa_rsp_t rsp;
    int       slot;
    rsp = '0;
    case (req.action)
      ACT_ALLOC: begin
        slot = lowest_free_slot();
        if (slot < 0) begin
          // No free slot: age every rank, then search again. If still none,
          // the encoder falls back to slot zero.
          rsp.evicted = 1'b1;
          for (int i = 0; i < SLOT_COUNT; i++) begin
            slot_rank_q[i] = slot_rank_q[i] - lsa_rank_t'(1);
          end
          slot = lowest_free_slot();
          if (slot < 0) slot = 0;
        end
        rsp.granted_slot = slot[IDX_W-1:0];
        promote_slot(slot);
      end
      ACT_TOUCH:   promote_slot(int'(req.slot_index));
      ACT_DEALLOC: slot_rank_q[req.slot_index] = lsa_rank_t'(-1);
      default: ;   // unused code: state unchanged, only the status is reported
    endcase
    for (int i = 0; i < SLOT_COUNT; i++) begin
      if (slot_rank_q[i] > 0) begin
        rsp.used_mask[i] = 1'b1;
        rsp.used_count   = rsp.used_count + COUNT_W'(1);
      end
    end
    // Only a negative rank counts as free for the query.
    rsp.queried_free = slot_rank_q[req.slot_index] < 0;
    return rsp;
  endfunction

  // --------------------------------------------------------------------------
  // Driver: offer the backlog, predict on every accepted transfer
  // --------------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid <= 1'b0;
      in_data  <= '0;
      req_sent <= 0;
      for (int i = 0; i < SLOT_COUNT; i++) slot_rank_q[i] = lsa_rank_t'(-1);
    end else begin
      if (in_valid && !in_stall) begin
        rsp_due_q.push_back(apply_action(in_data));
        req_sent <= req_sent + 1;
      end
      // Hold a stalled payload; otherwise advance or idle at random.
      if (!in_valid || !in_stall) begin
        if (req_backlog_q.size() != 0 &&
            (sender_quiet || $urandom_range(99) >= IDLE_PCT)) begin
          in_valid <= 1'b1;
          in_data  <= req_backlog_q.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: compare each response transfer with the oldest prediction
  // --------------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin : rsp_check
    lsa_rsp_t want;
    if (!rst_ni) begin
      rsp_taken <= 0;
    end else if (out_valid && !out_stall) begin
      rsp_taken <= rsp_taken + 1;
      if (rsp_due_q.size() == 0) begin
        mismatch_cnt++;
        if (mismatch_cnt <= REPORT_MAX)
          $display({"%0t: response with none due: granted=%0d evicted=%0d ",
                    "mask=%h count=%0d free=%0d"},
                   $realtime, out_data.granted_slot, out_data.evicted, out_data.used_mask,
                   out_data.used_count, out_data.queried_free);
      end else begin
        want = rsp_due_q.pop_front();
        if (out_data.granted_slot !== want.granted_slot ||
            out_data.evicted      !== want.evicted      ||
            out_data.used_mask    !== want.used_mask    ||
            out_data.used_count   !== want.used_count   ||
            out_data.queried_free !== want.queried_free) begin
          mismatch_cnt++;
          if (mismatch_cnt <= REPORT_MAX)
            $display({"%0t: response %0d differs: exp granted=%0d evicted=%0d mask=%h ",
                      "count=%0d free=%0d, got granted=%0d evicted=%0d mask=%h ",
                      "count=%0d free=%0d"},
                     $realtime, rsp_taken, want.granted_slot, want.evicted, want.used_mask,
                     want.used_count, want.queried_free, out_data.granted_slot,
                     out_data.evicted, out_data.used_mask, out_data.used_count,
                     out_data.queried_free);
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Receiver stall: random back-pressure plus one long hold, counted here,
  // so the output register and the sequencer fill and the input stalls.
  // --------------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall <= 1'b0;
      hold_left <= 0;
      hold_done <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else if (!hold_done && rsp_taken >= HOLD_AT) begin
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= !receiver_quiet && ($urandom_range(99) < IDLE_PCT);
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus and end of run
  // --------------------------------------------------------------------------
  function automatic void queue_req(logic [ACT_W-1:0] act, int slot);
    lsa_req_t req;
    req.action     = act;
    req.slot_index = slot[IDX_W-1:0];
    req_backlog_q.push_back(req);
  endfunction

  initial begin
    int first_random;
    int burst;
    int slot;

    // Directed: free slot released, touch from free and on top, allocate,
    // unused code, releases at both ends, then a run of twelve allocates.
    queue_req(ACT_DEALLOC, 3);
    queue_req(ACT_TOUCH,   15);
    queue_req(ACT_TOUCH,   15);
    queue_req(ACT_ALLOC,   15);
    queue_req(ACT_ALLOC,   0);
    queue_req(ACT_UNUSED,  0);
    queue_req(ACT_UNUSED,  15);
    queue_req(ACT_TOUCH,   0);
    queue_req(ACT_DEALLOC, 15);
    queue_req(ACT_DEALLOC, 0);
    for (int i = 0; i < 12; i++) queue_req(ACT_ALLOC, i + 4);
    queue_req(ACT_TOUCH,   5);
    queue_req(ACT_DEALLOC, 5);

    // Random: bursts that fill the row, churn the order, free and refill,
    // and a share of plain noise with the unused code.
    first_random = req_backlog_q.size();
    while (req_backlog_q.size() - first_random < RANDOM_REQS) begin
      case ($urandom_range(3))
        0: begin
          burst = $urandom_range(24, 8);
          for (int i = 0; i < burst; i++) queue_req(ACT_ALLOC, $urandom_range(15));
        end
        1: begin
          burst = $urandom_range(12, 4);
          for (int i = 0; i < burst; i++) begin
            slot = $urandom_range(15);
            queue_req(ACT_TOUCH, slot);
            if ($urandom_range(2) == 0) queue_req(ACT_TOUCH, slot);
          end
        end
        2: begin
          burst = $urandom_range(6, 2);
          for (int i = 0; i < burst; i++) queue_req(ACT_DEALLOC, $urandom_range(15));
          for (int i = 0; i < burst; i++) queue_req(ACT_ALLOC, $urandom_range(15));
        end
        default: begin
          for (int i = 0; i < 20; i++) begin
            queue_req(ACT_W'($urandom_range(3)), $urandom_range(15));
          end
        end
      endcase
    end

    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Sample at the falling edge, clear of the updates at the rising edge.
    do begin
      @(negedge clk_i);
    end while (req_backlog_q.size() != 0 || in_valid || rsp_due_q.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (mismatch_cnt == 0 && rsp_due_q.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin
    #(TIMEOUT_NS);
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
